// ----- design/pbnc_pkg.sv -----
// Package for the palette blend / nearest-color core.
// Holds sizes, opcodes, shared structs and the divide-by-255 helper; no dependencies.
package pbnc_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
    localparam int unsigned ENTRY_W = 8;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned MIX_W  = 2 * CH_W;
    localparam int unsigned DIST_W = 2 * CH_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_scan_tag;

    // exact x/255 for x below 65280
    function automatic logic [CH_W-1:0] div255(input logic [MIX_W-1:0] x);
        logic [MIX_W:0] t;
        t = (MIX_W+1)'(x) + (MIX_W+1)'(x >> CH_W) + (MIX_W+1)'(1);
        return t[MIX_W-1:CH_W];
    endfunction

endpackage

// ----- design/pbnc_channels.sv -----
// Request and response channel interfaces of the palette blend core.
// Depends on pbnc_pkg for field widths.
interface pbnc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [pbnc_pkg::ENTRY_W-1:0] entry_index;
    logic [pbnc_pkg::CH_W-1:0]    color_red;
    logic [pbnc_pkg::CH_W-1:0]    color_green;
    logic [pbnc_pkg::CH_W-1:0]    color_blue;
    logic [pbnc_pkg::CH_W-1:0]    blend_alpha;

    modport source (output valid, opcode, entry_index, color_red, color_green, color_blue,
                    blend_alpha, input ready);
    modport sink   (input valid, opcode, entry_index, color_red, color_green, color_blue,
                    blend_alpha, output ready);
endinterface

interface pbnc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pbnc_pkg::ENTRY_W-1:0] nearest_index;

    modport source (output valid, nearest_index, input ready);
    modport sink   (input valid, nearest_index, output ready);
endinterface

// ----- design/pbnc_palette_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module pbnc_palette_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pbnc_blend.sv -----
// Channel-serial alpha blend: one channel multiply per cycle, then divide by 255.
// Depends on pbnc_pkg.
module pbnc_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pbnc_pkg::t_rgb                i_src,
    input  pbnc_pkg::t_rgb                i_tgt,
    input  logic [pbnc_pkg::CH_W-1:0]     i_alpha,
    output logic                          o_done,
    output pbnc_pkg::t_rgb                o_rgb
);

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    pbnc_pkg::t_rgb                r_src;
    pbnc_pkg::t_rgb                r_tgt;
    logic [pbnc_pkg::CH_W-1:0]     r_alpha;
    logic                          r_busy;
    logic [1:0]                    r_ch;
    logic [pbnc_pkg::MIX_W-1:0]    r_mix;
    logic [1:0]                    r_mix_ch;
    logic                          r_mix_vld;
    logic                          r_done;
    logic [pbnc_pkg::CH_W-1:0]     r_red;
    logic [pbnc_pkg::CH_W-1:0]     r_green;
    logic [pbnc_pkg::CH_W-1:0]     r_blue;

    logic [pbnc_pkg::CH_W-1:0]     w_s;
    logic [pbnc_pkg::CH_W-1:0]     w_t;
    logic [pbnc_pkg::CH_W-1:0]     w_inv;
    logic [pbnc_pkg::MIX_W-1:0]    n_mix;
    logic [pbnc_pkg::CH_W-1:0]     w_q;

    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_s = r_src.red;
                w_t = r_tgt.red;
            end
            CH_GREEN: begin
                w_s = r_src.green;
                w_t = r_tgt.green;
            end
            default: begin
                w_s = r_src.blue;
                w_t = r_tgt.blue;
            end
        endcase
        w_inv = 8'd255 - r_alpha;
        n_mix = pbnc_pkg::MIX_W'(w_s) * pbnc_pkg::MIX_W'(w_inv)
              + pbnc_pkg::MIX_W'(w_t) * pbnc_pkg::MIX_W'(r_alpha)
              + pbnc_pkg::MIX_W'(127);
        w_q = pbnc_pkg::div255(r_mix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ch      <= CH_RED;
            r_mix_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_mix_vld <= r_busy;
            r_done    <= r_mix_vld && (r_mix_ch == CH_BLUE);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ch   <= CH_RED;
            end else if (r_busy) begin
                r_ch <= r_ch + 2'd1;
                if (r_ch == CH_BLUE) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src   <= i_src;
            r_tgt   <= i_tgt;
            r_alpha <= i_alpha;
        end
        if (r_busy) begin
            r_mix    <= n_mix;
            r_mix_ch <= r_ch;
        end
        if (r_mix_vld) begin
            case (r_mix_ch)
                CH_RED:   r_red   <= w_q;
                CH_GREEN: r_green <= w_q;
                default:  r_blue  <= w_q;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rgb  = '{red: r_red, green: r_green, blue: r_blue};

endmodule

// ----- design/pbnc_search.sv -----
// Distance pipeline (absolute difference, square, sum) and running minimum over the palette scan.
// Depends on pbnc_pkg.
module pbnc_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  pbnc_pkg::t_scan_tag        i_tag,
    input  pbnc_pkg::t_rgb             i_pix,
    input  pbnc_pkg::t_rgb             i_ref,
    output logic                       o_done,
    output logic [pbnc_pkg::IDX_W-1:0] o_best
);

    logic                         r_v1;
    logic                         r_v2;
    pbnc_pkg::t_scan_tag          r_tag1;
    pbnc_pkg::t_scan_tag          r_tag2;
    logic [pbnc_pkg::CH_W-1:0]    r_dr;
    logic [pbnc_pkg::CH_W-1:0]    r_dg;
    logic [pbnc_pkg::CH_W-1:0]    r_db;
    logic [pbnc_pkg::MIX_W-1:0]   r_sr;
    logic [pbnc_pkg::MIX_W-1:0]   r_sg;
    logic [pbnc_pkg::MIX_W-1:0]   r_sb;
    logic [pbnc_pkg::DIST_W-1:0]  r_best_dist;
    logic [pbnc_pkg::IDX_W-1:0]   r_best_idx;
    logic                         r_done;

    logic [pbnc_pkg::DIST_W-1:0]  w_dist;
    logic                         w_take;

    function automatic logic [pbnc_pkg::CH_W-1:0] absdiff(input logic [pbnc_pkg::CH_W-1:0] a,
                                                        input logic [pbnc_pkg::CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_dist = pbnc_pkg::DIST_W'(r_sr) + pbnc_pkg::DIST_W'(r_sg)
                  + pbnc_pkg::DIST_W'(r_sb);
    assign w_take = r_v2 && (r_tag2.first || (w_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_tag2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_dr   <= absdiff(i_pix.red,   i_ref.red);
        r_dg   <= absdiff(i_pix.green, i_ref.green);
        r_db   <= absdiff(i_pix.blue,  i_ref.blue);
        r_tag2 <= r_tag1;
        r_sr   <= pbnc_pkg::MIX_W'(r_dr) * pbnc_pkg::MIX_W'(r_dr);
        r_sg   <= pbnc_pkg::MIX_W'(r_dg) * pbnc_pkg::MIX_W'(r_dg);
        r_sb   <= pbnc_pkg::MIX_W'(r_db) * pbnc_pkg::MIX_W'(r_db);
        if (w_take) begin
            r_best_dist <= w_dist;
            r_best_idx  <= r_tag2.idx;
        end
    end

    assign o_done = r_done;
    assign o_best = r_best_idx;

endmodule

// ----- design/palette_blend_nearest_color_core.sv -----
// Top level: request decode, scan sequencer, palette RAM, blend and search units.
// Depends on pbnc_pkg, pbnc_channels, pbnc_palette_ram, pbnc_blend, pbnc_search.
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    opcode, entry_index, color_red/green/blue, blend_alpha
//   o_rsp    out  valid/ready    nearest_index
//
// A query does one source read, the blend, one RAM read per palette entry during the
// scan, and the search pipeline drain.
// One request is in work at a time; writes are taken while a result waits in o_rsp.
// Reset is synchronous active low and clears control only; the palette is not cleared.
// A stalled o_rsp holds the next query's result in the search unit until the slot frees.
module palette_blend_nearest_color_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pbnc_req_if.sink       i_req,
    pbnc_rsp_if.source     o_rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRC   = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_PUT   = 3'd5;

    localparam logic [pbnc_pkg::IDX_W-1:0] LAST_IDX =
        pbnc_pkg::IDX_W'(pbnc_pkg::PALETTE_ENTRIES - 1);

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [pbnc_pkg::IDX_W-1:0]     r_addr;
    logic                           r_src_ok;
    pbnc_pkg::t_rgb                 r_tgt;
    logic [pbnc_pkg::CH_W-1:0]      r_alpha;
    logic                           r_scan_vld;
    pbnc_pkg::t_scan_tag            r_scan_tag;
    logic                           r_out_valid;
    logic [pbnc_pkg::ENTRY_W-1:0]   r_out_idx;

    logic                           w_acc;
    logic                           w_in_range;
    logic                           w_we;
    logic                           w_re;
    logic [pbnc_pkg::IDX_W-1:0]     w_raddr;
    pbnc_pkg::t_rgb                 w_rdata;
    pbnc_pkg::t_rgb                 w_src;
    pbnc_pkg::t_rgb                 w_wdata;
    pbnc_pkg::t_rgb                 w_blend_rgb;
    logic                           w_blend_done;
    logic                           w_search_done;
    logic [pbnc_pkg::IDX_W-1:0]     w_best;
    logic                           w_out_free;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_in_range  = ({1'b0, i_req.entry_index} <
                          (pbnc_pkg::ENTRY_W+1)'(pbnc_pkg::PALETTE_ENTRIES));
    assign w_we        = w_acc && (i_req.opcode == pbnc_pkg::OP_WRITE) && w_in_range;
    assign w_re        = (w_acc && (i_req.opcode == pbnc_pkg::OP_QUERY))
                      || (r_state == ST_SCAN);
    assign w_raddr     = (r_state == ST_IDLE) ? i_req.entry_index[pbnc_pkg::IDX_W-1:0]
                                              : r_addr;
    assign w_wdata     = '{red: i_req.color_red, green: i_req.color_green,
                           blue: i_req.color_blue};
    assign w_src       = r_src_ok ? w_rdata : '0;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    pbnc_palette_ram #(
        .DEPTH (pbnc_pkg::PALETTE_ENTRIES),
        .WIDTH ($bits(pbnc_pkg::t_rgb))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_req.entry_index[pbnc_pkg::IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pbnc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SRC),
        .i_src   (w_src),
        .i_tgt   (r_tgt),
        .i_alpha (r_alpha),
        .o_done  (w_blend_done),
        .o_rgb   (w_blend_rgb)
    );

    pbnc_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_scan_vld),
        .i_tag   (r_scan_tag),
        .i_pix   (w_rdata),
        .i_ref   (w_blend_rgb),
        .o_done  (w_search_done),
        .o_best  (w_best)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_req.opcode == pbnc_pkg::OP_QUERY)) begin
                    n_state = ST_SRC;
                end
            end
            ST_SRC:   n_state = ST_BLEND;
            ST_BLEND: begin
                if (w_blend_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_search_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_scan_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_vld <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_addr <= r_addr + pbnc_pkg::IDX_W'(1);
            end else begin
                r_addr <= '0;
            end
            if ((r_state == ST_PUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_src_ok <= w_in_range;
            r_tgt    <= w_wdata;
            r_alpha  <= i_req.blend_alpha;
        end
        r_scan_tag <= '{first: (r_addr == '0), last: (r_addr == LAST_IDX), idx: r_addr};
        if ((r_state == ST_PUT) && w_out_free) begin
            r_out_idx <= pbnc_pkg::ENTRY_W'(w_best);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.nearest_index = r_out_idx;

    a_blend_done_in_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blend_done |-> (r_state == ST_BLEND))
        else $error("blend done outside blend phase");

    a_search_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_search_done |-> (r_state == ST_WAIT))
        else $error("search done outside wait phase");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_IDLE))
        else $error("palette write while a query is in work");

    a_put_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PUT) && r_out_valid && !o_rsp.ready) |=> (r_state == ST_PUT))
        else $error("result dropped while output slot busy");

endmodule
